// ===== hdl/aligned_range_splitter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the aligned range splitter checker
// ---------------------------------------------------------------------------
`ifndef ALIGNED_RANGE_SPLITTER_UNIT_MACROS_SVH
`define ALIGNED_RANGE_SPLITTER_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ARS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define ARS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/ars_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_pkg
// Types and constants shared by the aligned range splitter modules.
// ---------------------------------------------------------------------------
package ars_pkg;

   // Result limit per input range
   localparam int unsigned MAX_RESULTS = 62;
   localparam int unsigned CNT_WIDTH   = $clog2(MAX_RESULTS + 1);

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGE_ORDER = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPACE_ID   = 2'd1;

   typedef struct packed {
      logic [31:0] base_addr;
      logic [31:0] range_len;
   } ars_req_type;

   typedef struct packed {
      logic [31:0] block_base;
      logic [4:0]  block_order;
      logic [7:0]  target_space;
      logic        last_block;
   } ars_rsp_type;

   // Core to output stage: one new block, or end of range
   typedef struct packed {
      logic        push;
      logic        finish;
      logic [31:0] block_base;
      logic [4:0]  block_order;
   } ars_push_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROW,
      ST_SHRINK,
      ST_FLUSH
   } ars_state_type;

endpackage

// ===== hdl/ars_split_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_split_core
// Sequencer and shared shift/add datapath: walks the block order one step per
// cycle unless a block waits, growing from page order, then shrinking back.
// ---------------------------------------------------------------------------
module ars_split_core
   import ars_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ars_req_type  req_data,
   input  logic [4:0]   page_order,
   input  logic         push_ok,
   output ars_push_type push_out
);

   localparam int ORD_W = $clog2(ADDR_WIDTH + 1);
   localparam logic [ORD_W-1:0] AW_ORD   = ORD_W'(ADDR_WIDTH);
   localparam logic [ORD_W-1:0] TOP_ORD  = ORD_W'(ADDR_WIDTH - 1);
   localparam logic [ADDR_WIDTH-1:0] ONE = ADDR_WIDTH'(1);

   ars_state_type state_ff, state_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [ADDR_WIDTH-1:0] rem_ff, rem_in;
   logic [ORD_W-1:0]      ord_ff, ord_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   logic [ORD_W-1:0]      page_ext;
   logic [ADDR_WIDTH-1:0] hi_mask, in_addr, in_len;
   logic [ADDR_WIDTH-1:0] blk_size;
   logic                  accept, skip;
   logic                  fits, ord_lt_w, cnt_lt_max;
   logic                  grow_go, shr_go, shr_last;
   logic                  hit, advance;

   // Input masking: drop bits below the page order
   assign page_ext = ORD_W'(page_order);
   assign hi_mask  = {ADDR_WIDTH{1'b1}} << page_order;
   assign in_addr  = ADDR_WIDTH'({32'd0, req_data.base_addr}) & hi_mask;
   assign in_len   = ADDR_WIDTH'({32'd0, req_data.range_len}) & hi_mask;
   assign skip     = (page_ext >= AW_ORD) || (in_len == '0);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && !req_stall;

   // Shared shift unit: block size and remaining-length fit test
   assign blk_size   = ONE << ord_ff;
   assign fits       = |(rem_ff >> ord_ff);
   assign ord_lt_w   = ord_ff < AW_ORD;
   assign cnt_lt_max = cnt_ff < CNT_WIDTH'(MAX_RESULTS);

   assign grow_go  = ord_lt_w && fits && cnt_lt_max;
   assign shr_go   = (rem_ff != '0) && cnt_lt_max;
   assign shr_last = ord_ff <= page_ext;

   // Emit decision for the current order
   always_comb begin
      hit = 1'b0;
      unique case (state_ff)
         ST_GROW:   hit = grow_go && ((addr_ff & blk_size) != '0);
         ST_SHRINK: hit = shr_go && fits;
         default:   hit = 1'b0;
      endcase
   end

   // A block waits until the output stage can take it
   assign advance = !hit || push_ok;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !skip) state_in = ST_GROW;
         end
         ST_GROW: begin
            if (!grow_go) state_in = ST_SHRINK;
         end
         ST_SHRINK: begin
            if (!shr_go) state_in = ST_FLUSH;
            else if (advance && shr_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (push_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs toward the output stage
   always_comb begin
      push_out.push        = 1'b0;
      push_out.finish      = 1'b0;
      push_out.block_base  = 32'(addr_ff);
      push_out.block_order = ord_ff[4:0];
      unique case (state_ff)
         ST_GROW, ST_SHRINK: push_out.push = hit && push_ok;
         ST_FLUSH:           push_out.finish = 1'b1;
         default:            push_out.push = 1'b0;
      endcase
   end

   // Datapath updates
   always_comb begin
      addr_in = addr_ff;
      rem_in  = rem_ff;
      ord_in  = ord_ff;
      cnt_in  = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in = in_addr;
               rem_in  = in_len;
               ord_in  = page_ext;
               cnt_in  = '0;
            end
         end
         ST_GROW: begin
            if (!grow_go) begin
               ord_in = ord_lt_w ? ord_ff : TOP_ORD;
            end else if (advance) begin
               if (hit) begin
                  addr_in = addr_ff + blk_size;
                  rem_in  = rem_ff - blk_size;
                  cnt_in  = cnt_ff + CNT_WIDTH'(1);
               end
               ord_in = ord_ff + ORD_W'(1);
            end
         end
         ST_SHRINK: begin
            if (shr_go && advance) begin
               if (hit) begin
                  addr_in = addr_ff + blk_size;
                  rem_in  = rem_ff - blk_size;
                  cnt_in  = cnt_ff + CNT_WIDTH'(1);
               end
               if (!shr_last) ord_in = ord_ff - ORD_W'(1);
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      ord_ff  <= ord_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== hdl/ars_out_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_out_stage
// Holds one block back so the final block of a range can be flagged, and
// drives the registered result channel.
// ---------------------------------------------------------------------------
module ars_out_stage
   import ars_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ars_push_type push_in,
   input  logic [7:0]   space_id,
   output logic         push_ok,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ars_rsp_type  rsp_data
);

   logic        pend_valid_ff, pend_valid_in;
   ars_rsp_type pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ars_rsp_type rsp_ff, rsp_in;
   logic        out_can_load, load_mid, load_last;

   assign out_can_load = !rsp_valid_ff || !rsp_stall;
   assign push_ok      = !pend_valid_ff || out_can_load;
   assign load_mid     = push_in.push && pend_valid_ff;
   assign load_last    = push_in.finish && pend_valid_ff && out_can_load;

   // Pending block
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (push_in.push) begin
         pend_valid_in        = 1'b1;
         pend_in.block_base   = push_in.block_base;
         pend_in.block_order  = push_in.block_order;
         pend_in.target_space = space_id;
         pend_in.last_block   = 1'b0;
      end else if (load_last) begin
         pend_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load_mid || load_last) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = pend_ff;
         rsp_in.last_block  = load_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/aligned_range_splitter_unit.sv =====
`timescale 1ns / 1ps
// Holding: a block waits in a one-deep holding stage until the next block or the range end
//   arrives, then moves on to the registered result channel.
// Throughput: one order step per cycle through the shared shift/add unit while the output
//   stage takes each block, growing then shrinking; a new range waits for the last to end.
// A zero-length or sub-page range frees the input again the next cycle.
// Reset (synchronous, active high): idle, no result pending, page_order 12, space_id 0.
// ---------------------------------------------------------------------------
// aligned_range_splitter_unit
// Splits an address range into naturally aligned power-of-two unmap blocks.
// ---------------------------------------------------------------------------
module aligned_range_splitter_unit
   import ars_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ars_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ars_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [4:0]   page_order_ff, page_order_in;
   logic [7:0]   space_id_ff, space_id_in;
   ars_push_type push;
   logic         push_ok;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      page_order_in = page_order_ff;
      space_id_in   = space_id_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAGE_ORDER: page_order_in = csr_wdata[4:0];
            CSR_SPACE_ID:   space_id_in   = csr_wdata;
            default:        page_order_in = page_order_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_order_ff <= 5'd12;
         space_id_ff   <= 8'd0;
      end else begin
         page_order_ff <= page_order_in;
         space_id_ff   <= space_id_in;
      end
   end

   ars_split_core #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .page_order (page_order_ff),
      .push_ok    (push_ok),
      .push_out   (push)
   );

   ars_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .space_id  (space_id_ff),
      .push_ok   (push_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/ars_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_checker
// Port-level checks for the aligned range splitter, bound to the top level.
// ---------------------------------------------------------------------------
`include "aligned_range_splitter_unit_macros.svh"

module ars_checker
   import ars_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input ars_rsp_type rsp_data
);

   logic        rsp_held;
   logic        rsp_mid;
   logic [31:0] base_low_bits;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_mid       = rsp_valid && !rsp_data.last_block;
   assign base_low_bits = rsp_data.block_base & ((32'd1 << rsp_data.block_order) - 32'd1);

   // Stalled result holds its transfer
   `ARS_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // Out of reset the block is idle and shows nothing
   `ARS_ASSERT_ALWAYS(a_reset_idle, reset |=> !req_stall && !rsp_valid, "not idle after reset")

   // Every block is naturally aligned to its size
   `ARS_ASSERT(a_aligned, rsp_valid |-> base_low_bits == 32'd0, "block base not aligned")

   // While a non-final block is shown, the range is still in progress
   `ARS_ASSERT(a_busy_mid, rsp_mid |-> req_stall, "input taken before range end")

endmodule

bind aligned_range_splitter_unit ars_checker u_ars_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
